// ----- sv/ebu_pkg.sv -----
// Shared constants, types and helpers of the edge-blending 2x pixel upscaler.
package ebu_pkg;

    localparam int WIDTH_CAP  = 1024;
    localparam int HEIGHT_CAP = 1024;

    localparam int PIX_W     = 32;
    localparam int POS_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = 2;
    localparam int NUM_BANKS = 3;

    localparam int COL_W  = $clog2(WIDTH_CAP);
    localparam int ROW_W  = $clog2(HEIGHT_CAP + 1);
    localparam int MAX_CW = (COL_W > SIZE_W) ? COL_W : SIZE_W;
    localparam int MAX_RW = (ROW_W > MAX_CW) ? ROW_W : MAX_CW;
    localparam int CMP_W  = MAX_RW + 1;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic              FMT_RGB565   = 1'b0;
    localparam logic              FMT_XRGB8888 = 1'b1;
    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd240;

    localparam logic [PIX_W-1:0] AVG_MASK_565  = 32'h0000_0821;
    localparam logic [PIX_W-1:0] AVG_MASK_8888 = 32'h0001_0101;
    localparam logic [PIX_W-1:0] PIX_MASK_565  = 32'h0000_FFFF;
    localparam logic [PIX_W-1:0] PIX_MASK_8888 = 32'hFFFF_FFFF;

    // pending block codes: block above, block to the left, block of the pixel itself
    localparam logic [2:0] PEND_UP   = 3'b001;
    localparam logic [2:0] PEND_LEFT = 3'b010;
    localparam logic [2:0] PEND_SELF = 3'b100;

    typedef struct packed {
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] d;
        logic [PIX_W-1:0] e;
    } t_nbr;

    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
    } t_quad;

    typedef struct packed {
        t_quad            quad;
        logic [POS_W-1:0] block_column;
        logic [POS_W-1:0] block_row;
        logic             last_of_run;
        logic             frame_done;
    } t_blk;

    typedef struct packed {
        logic [PIX_W-1:0]  pix;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
        logic              row_gt0;
        logic              row_gt1;
        logic              col_gt0;
        logic              col_gt1;
        logic              last_col;
    } t_s1;

    function automatic logic [SIZE_W-1:0] size_sat(input logic [SIZE_W-1:0] raw,
                                                   input int unsigned lim);
        logic [SIZE_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = SIZE_W'(1);
        end else if (32'(raw) > lim) begin
            v = SIZE_W'(lim);
        end
        return v;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_up(input logic [SLOT_W-1:0] s);
        return (s == '0) ? SLOT_W'(NUM_BANKS - 1) : s - SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_up2(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_BANKS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

// ----- sv/ebu_if.sv -----
// Stream interfaces of the upscaler: source pixels in, 2x2 blocks out.
interface ebu_pix_if import ebu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface ebu_blk_if import ebu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
    logic [POS_W-1:0] block_column;
    logic [POS_W-1:0] block_row;
    logic             last_of_run;
    logic             frame_done;

    modport source (output valid, output top_left, output top_right, output bottom_left,
                    output bottom_right, output block_column, output block_row,
                    output last_of_run, output frame_done, input ready);
    modport sink (input valid, input top_left, input top_right, input bottom_left,
                  input bottom_right, input block_column, input block_row,
                  input last_of_run, input frame_done, output ready);
endinterface

// ----- sv/ebu_corner.sv -----
// Corner rule: compare the four neighbors and blend each corner of one 2x2 block.
module ebu_corner import ebu_pkg::*; (
    input  logic  i_fmt,
    input  t_nbr  i_nbr,
    output t_quad o_quad
);

    function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] c,
                                               input logic [PIX_W-1:0] x,
                                               input logic [PIX_W-1:0] m);
        logic [PIX_W-1:0] s;
        s = c + x - ((c ^ x) & m);
        return s >> 1;
    endfunction

    logic [PIX_W-1:0] pmask;
    logic [PIX_W-1:0] amask;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] d;
    logic [PIX_W-1:0] e;
    logic             edge_on;

    always_comb begin
        pmask   = (i_fmt == FMT_XRGB8888) ? PIX_MASK_8888 : PIX_MASK_565;
        amask   = (i_fmt == FMT_XRGB8888) ? AVG_MASK_8888 : AVG_MASK_565;
        c       = i_nbr.c & pmask;
        a       = i_nbr.a & pmask;
        b       = i_nbr.b & pmask;
        d       = i_nbr.d & pmask;
        e       = i_nbr.e & pmask;
        edge_on = (a != e) && (b != d);

        o_quad.tl = (edge_on && a == b) ? blend(c, a, amask) : c;
        o_quad.tr = (edge_on && a == d) ? blend(c, a, amask) : c;
        o_quad.bl = (edge_on && e == b) ? blend(c, e, amask) : c;
        o_quad.br = (edge_on && e == d) ? blend(c, e, amask) : c;
    end

endmodule

// ----- sv/edge_blend_2x_pixel_upscaler.sv -----
// Edge-blending 2x upscaler top level: line banks, neighbor window, block output register.
//
// Source pixels enter in raster order, one per clock while i_pix.ready is high; each
// is turned into a 2x2 block once the pixel below it has arrived. Rows above the last one
// sustain one pixel per cycle while the output accepts blocks; in the last row each
// pixel also flushes the block to its left, and the final pixel its own block, stalling
// the input. The single output register takes one block per cycle when the sink is
// ready; blocks are built from r_s1 and held in r_out. Three row banks of WIDTH_CAP words
// hold the line store; they are never cleared and never read before written within a
// frame. Any register write restarts the frame at row 0, column 0; write only when idle.
module edge_blend_2x_pixel_upscaler import ebu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIZE_W-1:0]    i_cfg_data,
    ebu_pix_if.sink              i_pix,
    ebu_blk_if.source            o_blk
);

    logic              r_fmt;
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [PIX_W-1:0]  r_rd_lo [NUM_BANKS];
    logic [PIX_W-1:0]  r_rd_hi [NUM_BANKS];

    t_s1               r_s1;
    t_s1               n_s1;
    logic [2:0]        r_s1_pend;
    logic [2:0]        n_pend;
    logic [PIX_W-1:0]  r_q1;
    logic [PIX_W-1:0]  r_q2;
    logic [PIX_W-1:0]  r_p1p;

    logic              r_out_valid;
    t_blk              r_out;
    t_blk              n_out;

    logic              in_acc;
    logic              cfg_hit;
    logic              last_col;
    logic              last_row;
    logic [COL_W-1:0]  col_nxt;
    logic [2:0]        sel;
    logic [2:0]        pend_rest;
    logic              out_load;
    logic [SLOT_W-1:0] bank_up;
    logic [SLOT_W-1:0] bank_up2;
    logic [PIX_W-1:0]  p1;
    logic [PIX_W-1:0]  p1n;
    logic [PIX_W-1:0]  p2;
    t_nbr              nbr;
    t_quad             quad;
    logic [COL_W-1:0]  blk_col;
    logic [ROW_W-1:0]  blk_row;

    assign in_acc   = i_pix.valid && i_pix.ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_index == REG_PIXEL_FORMAT
                      || i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);
    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) == CMP_W'(r_width);
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) == CMP_W'(r_height);
    assign col_nxt  = r_col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_RGB565;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PIXEL_FORMAT: r_fmt    <= i_cfg_data[0];
                    REG_FRAME_WIDTH:  r_width  <= size_sat(i_cfg_data, WIDTH_CAP);
                    REG_FRAME_HEIGHT: r_height <= size_sat(i_cfg_data, HEIGHT_CAP);
                    default: ;
                endcase
            end
            if (cfg_hit) begin
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
            end else if (in_acc) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + ROW_W'(1);
                        r_slot <= slot_up2(r_slot);
                    end
                end else begin
                    r_col <= col_nxt;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [PIX_W-1:0] r_mem [WIDTH_CAP];

        always_ff @(posedge i_clk) begin
            if (in_acc) begin
                if (r_slot == SLOT_W'(g)) begin
                    r_mem[r_col] <= i_pix.pixel_in;
                end
                r_rd_lo[g] <= r_mem[r_col];
                r_rd_hi[g] <= r_mem[col_nxt];
            end
        end
    end

    always_comb begin
        n_s1.pix      = i_pix.pixel_in;
        n_s1.col      = r_col;
        n_s1.row      = r_row;
        n_s1.slot     = r_slot;
        n_s1.row_gt0  = r_row != '0;
        n_s1.row_gt1  = r_row > ROW_W'(1);
        n_s1.col_gt0  = r_col != '0;
        n_s1.col_gt1  = r_col > COL_W'(1);
        n_s1.last_col = last_col;
        n_pend        = (r_row != '0) ? PEND_UP : '0;
        if (last_row && r_col != '0) begin
            n_pend = n_pend | PEND_LEFT;
        end
        if (last_row && last_col) begin
            n_pend = n_pend | PEND_SELF;
        end
    end

    assign sel         = r_s1_pend & (~r_s1_pend + 3'd1);
    assign pend_rest   = r_s1_pend & ~sel;
    assign out_load    = (r_s1_pend != '0) && (!r_out_valid || o_blk.ready);
    assign i_pix.ready = (r_s1_pend == '0) || (out_load && pend_rest == '0);

    assign bank_up  = slot_up(r_s1.slot);
    assign bank_up2 = slot_up2(r_s1.slot);
    assign p1       = r_rd_lo[bank_up];
    assign p1n      = r_rd_hi[bank_up];
    assign p2       = r_rd_lo[bank_up2];

    always_comb begin
        case (sel)
            PEND_UP: begin
                nbr.c   = p1;
                nbr.a   = r_s1.row_gt1 ? p2 : p1;
                nbr.b   = r_s1.col_gt0 ? r_p1p : p1;
                nbr.d   = r_s1.last_col ? p1 : p1n;
                nbr.e   = r_s1.pix;
                blk_col = r_s1.col;
                blk_row = r_s1.row - ROW_W'(1);
            end
            PEND_LEFT: begin
                nbr.c   = r_q1;
                nbr.a   = r_s1.row_gt0 ? r_p1p : r_q1;
                nbr.b   = r_s1.col_gt1 ? r_q2 : r_q1;
                nbr.d   = r_s1.pix;
                nbr.e   = r_q1;
                blk_col = r_s1.col - COL_W'(1);
                blk_row = r_s1.row;
            end
            default: begin
                nbr.c   = r_s1.pix;
                nbr.a   = r_s1.row_gt0 ? p1 : r_s1.pix;
                nbr.b   = r_s1.col_gt0 ? r_q1 : r_s1.pix;
                nbr.d   = r_s1.pix;
                nbr.e   = r_s1.pix;
                blk_col = r_s1.col;
                blk_row = r_s1.row;
            end
        endcase
    end

    ebu_corner u_corner (
        .i_fmt  (r_fmt),
        .i_nbr  (nbr),
        .o_quad (quad)
    );

    always_comb begin
        n_out.quad         = quad;
        n_out.block_column = POS_W'(blk_col);
        n_out.block_row    = POS_W'(blk_row);
        n_out.last_of_run  = pend_rest == '0;
        n_out.frame_done   = sel == PEND_SELF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_pend   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_pend <= n_pend;
            end else if (out_load) begin
                r_s1_pend <= pend_rest;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_blk.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // shift the row history as the next pixel takes the window
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1  <= n_s1;
            r_q1  <= r_s1.pix;
            r_q2  <= r_q1;
            r_p1p <= p1;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_blk.valid        = r_out_valid;
    assign o_blk.top_left     = r_out.quad.tl;
    assign o_blk.top_right    = r_out.quad.tr;
    assign o_blk.bottom_left  = r_out.quad.bl;
    assign o_blk.bottom_right = r_out.quad.br;
    assign o_blk.block_column = r_out.block_column;
    assign o_blk.block_row    = r_out.block_row;
    assign o_blk.last_of_run  = r_out.last_of_run;
    assign o_blk.frame_done   = r_out.frame_done;

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_blk.valid && o_blk.frame_done |-> o_blk.last_of_run)
        else $error("frame end block not marked last of run");

    a_ready_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready |-> $countones(r_s1_pend) <= 1)
        else $error("pixel taken while blocks still pending");

    a_self_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_pend & PEND_SELF) != '0 |-> r_s1.last_col)
        else $error("self block pending away from right edge");
`endif

endmodule
